// ===== design/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// ===== design/cfr_pkg.sv =====
// Shared types and constants of the clock frame replacement table.
package cfr_pkg;
    localparam int NumFramesDef = 64;
    localparam int PageW = 20;
    localparam int OwnerW = 16;
    localparam int CmdW = 3;
    localparam int FrameW = 6;
    localparam int CfgW = 7;
    localparam int StatusW = 2;

    localparam logic [CmdW-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CmdW-1:0] CMD_BIND  = 3'd1;
    localparam logic [CmdW-1:0] CMD_FREE  = 3'd2;
    localparam logic [CmdW-1:0] CMD_TOUCH = 3'd3;
    localparam logic [CmdW-1:0] CMD_PIN   = 3'd4;
    localparam logic [CmdW-1:0] CMD_UNPIN = 3'd5;

    localparam logic [StatusW-1:0] ST_OK     = 2'd0;
    localparam logic [StatusW-1:0] ST_NOPAGE = 2'd1;
    localparam logic [StatusW-1:0] ST_PINNED = 2'd2;

    // Datapath operation for the currently visited frame.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch request, clear walk index
        OP_SCAN_FREE, // step free search
        OP_PASS1,
        OP_PASS2,
        OP_PASS3,
        OP_FIND,      // pin/unpin lookup step
        OP_RDVIC,     // victim's memory entry read
        OP_DIRECT,    // bind/free/touch
        OP_PINWR,
        OP_PASSRST,   // restart walk at hand
        OP_FINISH     // drive result
    } t_op;

    typedef struct packed {
        logic hit;     // current frame matches the pass condition
        logic last;    // current walk step is the final one
        logic oor;     // request frame out of range
        logic is_cmd_valid;
    } t_stat;
endpackage

// ===== design/clock_frame_replacement.sv =====
// Top level of the clock frame replacement table.
// Usage:
//  - Raise start with a command while busy is low; the request is taken
//    at that edge. o_done strobes for one cycle with the result fields.
//  - Commands: allocate, bind, free, touch, pin, unpin. Codes 6 and 7 answer
//    all-zero fields.
//  - Bind/free/touch update the table directly; pin/unpin do a linear lookup
//    over the page memory, one frame per cycle; allocate scans for a free
//    frame and, when none exists, evicts after walking the free scan and up
//    to three passes.
//  - Only one request is in flight; busy stays high until o_done, and the next
//    request can be taken in the o_done cycle.
//  - frames_in_use is an APB register at address 0; write it only while idle.
//  - Reset (synchronous, active low) clears all per-frame flags, the hand and
//    sets frames_in_use to 64. Page/owner memory is not cleared.
//  - The receiver cannot stall: results must be taken in the strobe cycle.
module clock_frame_replacement #(
    parameter int NUM_FRAMES = cfr_pkg::NumFramesDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cfr_pkg::CmdW-1:0]      i_cmd,
    input  logic [cfr_pkg::FrameW-1:0]    i_frame,
    input  logic [cfr_pkg::PageW-1:0]     i_page,
    input  logic [cfr_pkg::OwnerW-1:0]    i_owner,
    input  logic                          i_set_accessed,
    input  logic                          i_set_dirty,
    output logic                          o_done,
    output logic [cfr_pkg::FrameW-1:0]    o_result_frame,
    output logic [cfr_pkg::StatusW-1:0]   o_status,
    output logic                          o_evicted,
    output logic                          o_writeback,
    output logic [cfr_pkg::PageW-1:0]     o_victim_page,
    output logic [cfr_pkg::OwnerW-1:0]    o_victim_owner,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cfr_pkg::*;
    t_op op;
    t_stat stat;
    logic [CfgW-1:0] r_cfg;
    logic done_c;

    // Configuration register: frames_in_use at byte address 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= CfgW'(64);
        else if (psel && penable && pwrite && paddr == 2'd0) r_cfg <= pwdata[CfgW-1:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(r_cfg) : '0;

    cfr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .o_done(done_c), .o_op(op), .i_stat(stat), .i_cmd(i_cmd)
    );

    cfr_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op), .o_stat(stat), .i_cfg(r_cfg),
        .i_cmd(i_cmd), .i_frame(i_frame), .i_page(i_page), .i_owner(i_owner),
        .i_set_accessed(i_set_accessed), .i_set_dirty(i_set_dirty),
        .o_result_frame(o_result_frame), .o_status(o_status), .o_evicted(o_evicted),
        .o_writeback(o_writeback), .o_victim_page(o_victim_page),
        .o_victim_owner(o_victim_owner)
    );
    assign o_done = done_c;
endmodule

// ===== design/cfr_datapath.sv =====
// Frame table storage and per-frame walk datapath.
module cfr_datapath #(
    parameter int NUM_FRAMES = cfr_pkg::NumFramesDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfr_pkg::t_op                  i_op,
    output cfr_pkg::t_stat                o_stat,
    input  logic [cfr_pkg::CfgW-1:0]      i_cfg,
    input  logic [cfr_pkg::CmdW-1:0]      i_cmd,
    input  logic [cfr_pkg::FrameW-1:0]    i_frame,
    input  logic [cfr_pkg::PageW-1:0]     i_page,
    input  logic [cfr_pkg::OwnerW-1:0]    i_owner,
    input  logic                          i_set_accessed,
    input  logic                          i_set_dirty,
    output logic [cfr_pkg::FrameW-1:0]    o_result_frame,
    output logic [cfr_pkg::StatusW-1:0]   o_status,
    output logic                          o_evicted,
    output logic                          o_writeback,
    output logic [cfr_pkg::PageW-1:0]     o_victim_page,
    output logic [cfr_pkg::OwnerW-1:0]    o_victim_owner
);
    import cfr_pkg::*;
    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int NW = $clog2(NUM_FRAMES + 1);
    localparam int XW = (NW > CfgW) ? NW : CfgW;

    logic [NUM_FRAMES-1:0] r_used, r_bval, r_acc, r_dirty, r_seen, r_pin;
    logic [PageW+OwnerW-1:0] r_mem [NUM_FRAMES];
    logic [PageW+OwnerW-1:0] r_rd;
    logic [IW-1:0] r_hand, r_idx, r_start, r_cnt;
    logic [CmdW-1:0] r_cmd;
    logic [FrameW-1:0] r_frame;
    logic [PageW-1:0] r_page;
    logic [OwnerW-1:0] r_owner;
    logic r_sa, r_sd, r_wb, r_ev, r_vbound;
    logic [StatusW-1:0] r_st;
    logic [IW-1:0] r_res;

    logic [XW-1:0] cfg_x, n_x;
    logic [IW-1:0] n_m1, idx_inc, start_c, frm_c;
    logic hit_c, req_oor;

    // effective frame count
    always_comb begin
        cfg_x = XW'(i_cfg);
        if (cfg_x == '0) n_x = XW'(1);
        else if (cfg_x > XW'(NUM_FRAMES)) n_x = XW'(NUM_FRAMES);
        else n_x = cfg_x;
        n_m1 = IW'(n_x - XW'(1));
        idx_inc = (r_idx == n_m1) ? '0 : r_idx + IW'(1);
        start_c = (XW'(r_hand) < n_x) ? r_hand : '0;
        req_oor = XW'(r_frame) >= n_x;
        frm_c = IW'(r_frame);
        case (i_op)
            OP_SCAN_FREE: hit_c = !r_used[r_idx];
            OP_PASS1:     hit_c = !r_acc[r_idx] && !r_dirty[r_idx] && !r_pin[r_idx];
            OP_PASS2:     hit_c = !r_seen[r_idx] && !r_pin[r_idx];
            OP_PASS3:     hit_c = !r_pin[r_idx];
            OP_FIND:      hit_c = r_bval[r_idx] && (r_rd == {r_page, r_owner});
            default:      hit_c = 1'b0;
        endcase
        o_stat.hit = hit_c;
        o_stat.last = (r_cnt == n_m1);
        o_stat.oor = req_oor;
        o_stat.is_cmd_valid = (r_cmd <= CMD_UNPIN);
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_op == OP_DIRECT && r_cmd == CMD_BIND && !req_oor)
            r_mem[frm_c] <= {r_page, r_owner};
        r_rd <= r_mem[(i_op == OP_LOAD) ? '0 :
                      (i_op == OP_FIND) ? idx_inc : r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0; r_bval <= '0; r_acc <= '0;
            r_dirty <= '0; r_seen <= '0; r_pin <= '0;
            r_hand <= '0;
        end else begin
            case (i_op)
                OP_LOAD: begin
                    r_cmd <= i_cmd; r_frame <= i_frame; r_page <= i_page;
                    r_owner <= i_owner; r_sa <= i_set_accessed; r_sd <= i_set_dirty;
                    r_idx <= '0; r_cnt <= '0; r_st <= ST_OK; r_ev <= 1'b0;
                    r_wb <= 1'b0; r_res <= '0; r_vbound <= 1'b0;
                end
                OP_SCAN_FREE: begin
                    if (hit_c) begin
                        r_used[r_idx] <= 1'b1; r_res <= r_idx;
                    end
                    r_idx <= r_idx + IW'(1); r_cnt <= r_cnt + IW'(1);
                end
                OP_PASSRST: begin
                    r_start <= start_c; r_idx <= start_c; r_cnt <= '0;
                end
                OP_PASS1, OP_PASS2, OP_PASS3: begin
                    if (hit_c) begin
                        r_res <= r_idx; r_ev <= 1'b1;
                        r_vbound <= r_bval[r_idx];
                        r_wb <= (i_op != OP_PASS1) && r_bval[r_idx];
                        r_hand <= (i_op == OP_PASS3) ? idx_inc :
                                  ((r_start == n_m1) ? '0 : r_start + IW'(1));
                        r_bval[r_idx] <= 1'b0; r_acc[r_idx] <= 1'b0;
                        r_dirty[r_idx] <= 1'b0; r_seen[r_idx] <= 1'b0;
                        r_pin[r_idx] <= 1'b0; r_used[r_idx] <= 1'b1;
                    end else begin
                        if (i_op == OP_PASS1 && r_acc[r_idx]) begin
                            r_acc[r_idx] <= 1'b0; r_seen[r_idx] <= 1'b1;
                        end
                        r_idx <= idx_inc; r_cnt <= r_cnt + IW'(1);
                    end
                end
                OP_RDVIC: ; // r_rd captures victim entry
                OP_FIND: begin
                    if (hit_c) r_res <= r_idx;
                    r_idx <= idx_inc; r_cnt <= r_cnt + IW'(1);
                end
                OP_PINWR: begin
                    r_pin[r_res] <= (r_cmd == CMD_PIN);
                    r_res <= '0;
                end
                OP_DIRECT: begin
                    if (req_oor) r_st <= ST_NOPAGE;
                    else if (r_cmd == CMD_BIND) r_bval[frm_c] <= 1'b1;
                    else if (r_cmd == CMD_FREE) begin
                        r_used[frm_c] <= 1'b0; r_bval[frm_c] <= 1'b0;
                        r_acc[frm_c] <= 1'b0; r_dirty[frm_c] <= 1'b0;
                    end else begin
                        if (r_sa) r_acc[frm_c] <= 1'b1;
                        if (r_sd) r_dirty[frm_c] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // status codes come from the controller via op sequence; kept simple here
    logic r_notfound, r_allpin;
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_notfound <= 1'b0; r_allpin <= 1'b0;
        end else if (i_op == OP_FIND && o_stat.last && !hit_c) begin
            r_notfound <= 1'b1;
        end else if (i_op == OP_PASS3 && o_stat.last && !hit_c) begin
            r_allpin <= 1'b1;
        end
    end

    always_comb begin
        o_result_frame = FrameW'(r_res);
        o_status = r_st;
        if (r_notfound) o_status = ST_NOPAGE;
        if (r_allpin) o_status = ST_PINNED;
        o_evicted = r_ev;
        o_writeback = r_wb;
        o_victim_page = r_vbound ? r_rd[PageW+OwnerW-1:OwnerW] : '0;
        o_victim_owner = r_vbound ? r_rd[OwnerW-1:0] : '0;
        if (r_cmd != CMD_ALLOC) o_result_frame = '0;
    end
endmodule

// ===== design/cfr_ctrl.sv =====
// Command sequencer of the clock frame replacement table.
module cfr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output logic            o_done,
    output cfr_pkg::t_op    o_op,
    input  cfr_pkg::t_stat  i_stat,
    input  logic [cfr_pkg::CmdW-1:0] i_cmd
);
    import cfr_pkg::*;
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FREE, S_PREP, S_P1, S_P2PREP, S_P2, S_P3PREP, S_P3,
        S_RDVIC, S_FIND, S_PINWR, S_DIRECT, S_OUT
    } t_state;
    t_state r_state;
    logic [CmdW-1:0] r_cmd;
    logic r_done;

    always_comb begin
        case (r_state)
            S_IDLE:    o_op = i_start ? OP_LOAD : OP_NONE;
            S_FREE:    o_op = OP_SCAN_FREE;
            S_PREP, S_P2PREP, S_P3PREP: o_op = OP_PASSRST;
            S_P1:      o_op = OP_PASS1;
            S_P2:      o_op = OP_PASS2;
            S_P3:      o_op = OP_PASS3;
            S_RDVIC:   o_op = OP_RDVIC;
            S_FIND:    o_op = OP_FIND;
            S_PINWR:   o_op = OP_PINWR;
            S_DIRECT:  o_op = OP_DIRECT;
            S_OUT:     o_op = OP_FINISH;
            default:   o_op = OP_NONE;
        endcase
        o_busy = (r_state != S_IDLE);
        o_done = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_done <= 1'b0; r_cmd <= CMD_ALLOC;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_cmd <= i_cmd; r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    if (!i_stat.is_cmd_valid) r_state <= S_OUT;
                    else if (r_cmd == CMD_ALLOC) r_state <= S_FREE;
                    else if (r_cmd == CMD_PIN || r_cmd == CMD_UNPIN) r_state <= S_FIND;
                    else r_state <= S_DIRECT;
                end
                S_FREE: if (i_stat.hit) r_state <= S_OUT;
                        else if (i_stat.last) r_state <= S_PREP;
                S_PREP: r_state <= S_P1;
                S_P1: if (i_stat.hit) r_state <= S_RDVIC;
                      else if (i_stat.last) r_state <= S_P2PREP;
                S_P2PREP: r_state <= S_P2;
                S_P2: if (i_stat.hit) r_state <= S_RDVIC;
                      else if (i_stat.last) r_state <= S_P3PREP;
                S_P3PREP: r_state <= S_P3;
                S_P3: if (i_stat.hit) r_state <= S_RDVIC;
                      else if (i_stat.last) r_state <= S_OUT;
                S_RDVIC: r_state <= S_OUT;
                S_FIND: if (i_stat.hit) r_state <= S_PINWR;
                        else if (i_stat.last) r_state <= S_OUT;
                S_PINWR: r_state <= S_OUT;
                S_DIRECT: r_state <= S_OUT;
                S_OUT: begin
                    r_done <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/cfr_checker.sv =====
// Port-level checker for the clock frame replacement table, with its bind.
`include "assert_macros.svh"
module cfr_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_evicted,
    input logic o_writeback,
    input logic [1:0] o_status
);
    import cfr_pkg::*;
    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "no busy after start")
    `CHK_IMPL(a_done_busy, i_clk, i_rst_n, o_done, !busy, "done while busy")
    `CHK_IMPL(a_wb_ev, i_clk, i_rst_n, o_done && o_writeback, o_evicted, "writeback w/o evict")
    `CHK_IMPL(a_pin_ev, i_clk, i_rst_n, o_done && o_status == ST_PINNED, !o_evicted, "pinned evict")
endmodule

bind clock_frame_replacement cfr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_evicted(o_evicted), .o_writeback(o_writeback), .o_status(o_status)
);

// ===== sim/frame_table_checker.sv =====
// Checker for the frame table: predicts each answer and compares it with the block.
`timescale 1ns / 1ps
module frame_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [5:0]  i_frame,
    input  logic [19:0] i_page,
    input  logic [15:0] i_owner,
    input  logic        i_set_accessed,
    input  logic        i_set_dirty,
    input  logic        o_done,
    input  logic [5:0]  o_result_frame,
    input  logic [1:0]  o_status,
    input  logic        o_evicted,
    input  logic        o_writeback,
    input  logic [19:0] o_victim_page,
    input  logic [15:0] o_victim_owner,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    import cfr_pkg::*;

    typedef struct packed {
        logic [5:0]  frame;
        logic [1:0]  status;
        logic        evicted;
        logic        writeback;
        logic [19:0] vpage;
        logic [15:0] vowner;
    } t_answer;

    localparam int NF = 64;
    localparam logic [1:0] ADDR_FRAMES = 2'd0;

    logic        used  [NF];
    logic        bound [NF];
    logic [19:0] bpage [NF];
    logic [15:0] bowner[NF];
    logic        acc   [NF];
    logic        dirty [NF];
    logic        seen  [NF];
    logic        pinned[NF];
    int          hand;
    logic [6:0]  frames_reg;
    t_answer     answers_due[$];

    assign o_pending = answers_due.size();

    task automatic evict(input int f, inout t_answer a);
        a.frame   = f[5:0];
        a.evicted = 1'b1;
        if (bound[f]) begin
            a.vpage  = bpage[f];
            a.vowner = bowner[f];
        end
        bound[f] = 0; acc[f] = 0; dirty[f] = 0; seen[f] = 0; pinned[f] = 0;
        used[f] = 1;
    endtask

    task automatic predict_answer(output t_answer a);
        int n, s, f, hit;
        logic wb;
        a = '0;
        n = (frames_reg == 0) ? 1 : (frames_reg > NF) ? NF : int'(frames_reg);
        case (i_cmd)
            CMD_ALLOC: begin
                hit = -1;
                for (int i = 0; i < n && hit < 0; i++)
                    if (!used[i]) hit = i;
                if (hit >= 0) begin
                    used[hit] = 1;
                    a.frame = hit[5:0];
                    return;
                end
                s = (hand < n) ? hand : 0;
                // first sweep: clean, unreferenced, unpinned; age referenced frames
                for (int i = 0; i < n; i++) begin
                    f = (s + i) % n;
                    if (!acc[f]) begin
                        if (!dirty[f] && !pinned[f]) begin
                            evict(f, a);
                            hand = (s + 1) % n;
                            return;
                        end
                    end else begin
                        acc[f] = 0;
                        seen[f] = 1;
                    end
                end
                for (int i = 0; i < n; i++) begin
                    f = (s + i) % n;
                    if (!seen[f] && !pinned[f]) begin
                        wb = bound[f];
                        evict(f, a);
                        a.writeback = wb;
                        hand = (s + 1) % n;
                        return;
                    end
                end
                for (int i = 0; i < n; i++) begin
                    f = (s + i) % n;
                    if (!pinned[f]) begin
                        wb = bound[f];
                        evict(f, a);
                        a.writeback = wb;
                        hand = (f + 1) % n;
                        return;
                    end
                end
                a.status = ST_PINNED;
            end
            CMD_BIND, CMD_FREE, CMD_TOUCH: begin
                f = int'(i_frame);
                if (f >= n) a.status = ST_NOPAGE;
                else if (i_cmd == CMD_BIND) begin
                    bpage[f] = i_page; bowner[f] = i_owner; bound[f] = 1;
                end else if (i_cmd == CMD_FREE) begin
                    used[f] = 0; bound[f] = 0; acc[f] = 0; dirty[f] = 0;
                end else begin
                    if (i_set_accessed) acc[f] = 1;
                    if (i_set_dirty) dirty[f] = 1;
                end
            end
            CMD_PIN, CMD_UNPIN: begin
                hit = -1;
                for (int i = 0; i < n && hit < 0; i++)
                    if (bound[i] && bpage[i] == i_page && bowner[i] == i_owner) hit = i;
                if (hit < 0) a.status = ST_NOPAGE;
                else pinned[hit] = (i_cmd == CMD_PIN);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_answer exp_a, got;
        if (!i_rst_n) begin
            for (int i = 0; i < NF; i++) begin
                used[i] = 0; bound[i] = 0; acc[i] = 0; dirty[i] = 0;
                seen[i] = 0; pinned[i] = 0; bpage[i] = '0; bowner[i] = '0;
            end
            hand = 0;
            frames_reg = 7'd64;
            answers_due.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_FRAMES)
                frames_reg = pwdata[6:0];
            if (o_done) begin
                got = '{o_result_frame, o_status, o_evicted, o_writeback,
                        o_victim_page, o_victim_owner};
                if (answers_due.size() == 0) begin
                    $error("unexpected answer strobe");
                    o_fail_count++;
                end else begin
                    exp_a = answers_due.pop_front();
                    if (got.frame !== exp_a.frame) begin
                        $error("result_frame exp %0d got %0d", exp_a.frame, got.frame);
                        o_fail_count++;
                    end
                    if (got.status !== exp_a.status) begin
                        $error("status exp %0d got %0d", exp_a.status, got.status);
                        o_fail_count++;
                    end
                    if (got.evicted !== exp_a.evicted) begin
                        $error("evicted exp %0d got %0d", exp_a.evicted, got.evicted);
                        o_fail_count++;
                    end
                    if (got.writeback !== exp_a.writeback) begin
                        $error("writeback exp %0d got %0d", exp_a.writeback, got.writeback);
                        o_fail_count++;
                    end
                    if (got.vpage !== exp_a.vpage) begin
                        $error("victim_page exp %0h got %0h", exp_a.vpage, got.vpage);
                        o_fail_count++;
                    end
                    if (got.vowner !== exp_a.vowner) begin
                        $error("victim_owner exp %0h got %0h", exp_a.vowner, got.vowner);
                        o_fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                predict_answer(exp_a);
                answers_due.push_back(exp_a);
            end
        end
    end
endmodule

// ===== sim/tb_clock_frame_replacement.sv =====
// Testbench top: drives requests and frame-count writes, reports the verdict.
`timescale 1ns / 1ps
module tb_clock_frame_replacement;
    import cfr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_cmd = '0;
    logic [5:0]  i_frame = '0;
    logic [19:0] i_page = '0;
    logic [15:0] i_owner = '0;
    logic        i_set_accessed = 1'b0;
    logic        i_set_dirty = 1'b0;
    logic        o_done, o_evicted, o_writeback;
    logic [5:0]  o_result_frame;
    logic [1:0]  o_status;
    logic [19:0] o_victim_page;
    logic [15:0] o_victim_owner;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;

    localparam logic [1:0] ADDR_FRAMES = 2'd0;
    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;
    // worst allocate walks the free scan and three passes over 64 frames
    localparam int DRAIN_CYCLES = 4 * 64 + 16;

    int          cur_n;         // managed frames as the block sees them
    int          idle_pct;      // chance of a gap after each request
    logic [19:0] pool_page[8];  // small page/owner pool so pin/unpin often hit
    logic [15:0] pool_owner[8];

    clock_frame_replacement i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .i_frame, .i_page, .i_owner,
        .i_set_accessed, .i_set_dirty, .o_done, .o_result_frame, .o_status,
        .o_evicted, .o_writeback, .o_victim_page, .o_victim_owner,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    frame_table_checker i_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .i_frame, .i_page, .i_owner,
        .i_set_accessed, .i_set_dirty, .o_done, .o_result_frame, .o_status,
        .o_evicted, .o_writeback, .o_victim_page, .o_victim_owner,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(12 * 3_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // Present one request and hold it until the block takes it.
    // Called right after a rising edge; start is raised once and not toggled while waiting.
    task automatic send_request(input logic [2:0] c, input logic [5:0] f,
                                input logic [19:0] p, input logic [15:0] o,
                                input logic sa, input logic sd);
        int gap;
        logic taken;
        i_cmd <= c; i_frame <= f; i_page <= p; i_owner <= o;
        i_set_accessed <= sa; i_set_dirty <= sd;
        start <= 1'b1;
        // busy is settled mid-cycle for the coming edge
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        // optional sender gap after the accepted request
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every answer is back plus the walk latency,
    // covering requests whose answer cannot have arrived yet.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the frame count: setup, access, then release.
    task automatic set_frames(input logic [6:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_FRAMES; pwdata <= {25'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        cur_n = (v == 0) ? 1 : (v > 64) ? 64 : int'(v);
    endtask

    // One random request, mostly well-formed traffic over the managed frames.
    task automatic random_request;
        int r, k;
        logic [2:0]  c;
        logic [5:0]  f;
        logic [19:0] p;
        logic [15:0] o;
        r = $urandom_range(99);
        k = $urandom_range(7);
        c = (r < 30) ? CMD_ALLOC : (r < 48) ? CMD_BIND : (r < 58) ? CMD_FREE :
            (r < 78) ? CMD_TOUCH : (r < 88) ? CMD_PIN : (r < 97) ? CMD_UNPIN :
            (r < 98) ? CMD_BAD6 : CMD_BAD7;
        // frames occasionally out of range
        f = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(cur_n - 1));
        p = pool_page[k];
        o = pool_owner[k];
        if ($urandom_range(9) == 0) begin
            p = 20'($urandom);
            o = 16'($urandom);
        end
        send_request(c, f, p, o, 1'($urandom), 1'($urandom));
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            pool_page[i]  = 20'($urandom);
            pool_owner[i] = 16'($urandom);
        end
        cur_n = 64;
        idle_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all commands, field extremes, lookup misses, bad codes
        send_request(CMD_ALLOC, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);
        send_request(CMD_BIND, 6'd0, 20'hfffff, 16'hffff, 1'b1, 1'b1);
        send_request(CMD_PIN, 6'd0, 20'hfffff, 16'hffff, 1'b0, 1'b0);
        send_request(CMD_TOUCH, 6'd0, 20'd0, 16'd0, 1'b1, 1'b1);
        send_request(CMD_TOUCH, 6'd63, 20'd0, 16'd0, 1'b0, 1'b0);
        send_request(CMD_UNPIN, 6'd0, 20'hfffff, 16'hffff, 1'b0, 1'b0);
        send_request(CMD_PIN, 6'd0, 20'h12345, 16'hffff, 1'b0, 1'b0);
        send_request(CMD_BIND, 6'd63, 20'd0, 16'd0, 1'b0, 1'b0);
        send_request(CMD_FREE, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);
        send_request(CMD_BAD6, 6'd63, 20'hfffff, 16'hffff, 1'b1, 1'b1);
        send_request(CMD_BAD7, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);
        drain();

        // two frames: fill, evict clean, evict dirty/referenced, all pinned
        set_frames(7'd2);
        send_request(CMD_BIND, 6'd5, 20'd1, 16'd1, 1'b0, 1'b0);   // out of range
        send_request(CMD_ALLOC, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);
        send_request(CMD_ALLOC, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);
        send_request(CMD_ALLOC, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);  // unbound victim
        send_request(CMD_BIND, 6'd0, 20'h00aaa, 16'h0055, 1'b0, 1'b0);
        send_request(CMD_BIND, 6'd1, 20'h00bbb, 16'h0066, 1'b0, 1'b0);
        send_request(CMD_TOUCH, 6'd0, 20'd0, 16'd0, 1'b1, 1'b1);
        send_request(CMD_TOUCH, 6'd1, 20'd0, 16'd0, 1'b0, 1'b1);
        send_request(CMD_ALLOC, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);  // writeback
        send_request(CMD_BIND, 6'd0, 20'h00ccc, 16'h0077, 1'b0, 1'b0);
        send_request(CMD_BIND, 6'd1, 20'h00ddd, 16'h0088, 1'b0, 1'b0);
        send_request(CMD_PIN, 6'd0, 20'h00ccc, 16'h0077, 1'b0, 1'b0);
        send_request(CMD_PIN, 6'd0, 20'h00ddd, 16'h0088, 1'b0, 1'b0);
        send_request(CMD_ALLOC, 6'd0, 20'd0, 16'd0, 1'b0, 1'b0);  // all pinned
        drain();

        // random phases over several frame counts, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_frames(7'd4);
                1: set_frames(7'd0);
                2: set_frames(7'd127);
                3: set_frames(7'd64);
                4: set_frames(7'd1);
                5: set_frames(7'd3);
                6: set_frames(7'd8);
                default: set_frames(7'd5);
            endcase
            idle_pct = (ph % 4 == 1) ? 45 : (ph % 4 == 3) ? 26 : 0;
            for (int i = 0; i < 50; i++) begin
                random_request();
                // hold off once until the table has answered everything
                if (ph == 0 && i == 25) begin
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
